>>> hdl/pair_sum_index_finder_assert.svh
// Assertion macros used by the pair-sum finder back end
`ifndef PAIR_SUM_INDEX_FINDER_ASSERT_SVH
`define PAIR_SUM_INDEX_FINDER_ASSERT_SVH

// Check a property on every clock edge outside reset
`define PSIF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a non-overlapping implication outside reset
`define PSIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/psif_pkg.sv
// Shared types and constants of the pair-sum finder
`timescale 1ns / 1ps
package psif_pkg;
  localparam int CAPACITY  = 1024;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int VAL_W     = 32;
  localparam int OUT_IDX_W = 10;
  localparam int ADDR_W    = 3;

  localparam logic [ADDR_W-1:0] REG_TARGET_SUM = 3'd0;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NONE     = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_EMIT
  } state_t;
endpackage

>>> hdl/psif_front.sv
// Front end: configuration register and request queue
`timescale 1ns / 1ps
module psif_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [psif_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 valid,
  output logic                                 stall,
  input  logic signed [psif_pkg::VAL_W-1:0]    element_value,
  input  logic                                 is_last,
  output logic signed [psif_pkg::VAL_W-1:0]    target_sum,
  output psif_pkg::head_t                      head,
  input  logic                                 pop
);
  import psif_pkg::*;

  item_t      q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;

  // Hold the target sum
  always_ff @(posedge clk) begin
    if (rst) begin
      target_sum <= '0;
    end else if (psel && penable && pwrite && paddr == REG_TARGET_SUM) begin
      target_sum <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TARGET_SUM) ? target_sum : 32'd0;

  // Two-entry request queue
  assign stall = (q_cnt == 2'd2);
  assign push  = valid && !stall;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= '{value: element_value, last: is_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (q_cnt != 2'd0);
  assign head.item  = q_mem[rd_ptr];
endmodule

>>> hdl/psif_back.sv
// Back end: key store scan, insert and result register
`timescale 1ns / 1ps
`include "pair_sum_index_finder_assert.svh"
module psif_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [psif_pkg::VAL_W-1:0]     target_sum,
  input  psif_pkg::head_t                       head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            status,
  output logic [psif_pkg::OUT_IDX_W-1:0]        first_index,
  output logic [psif_pkg::OUT_IDX_W-1:0]        second_index
);
  import psif_pkg::*;

  state_t                  state;
  state_t                  state_next;
  logic [VAL_W-1:0]        key_mem [CAPACITY];
  logic [VAL_W-1:0]        rdata;
  logic signed [VAL_W:0]   comp;
  logic signed [VAL_W:0]   head_comp;
  logic [VAL_W-1:0]        cur_value;
  logic                    cur_last;
  logic [IDX_W-1:0]        ptr;
  logic [CNT_W-1:0]        count;
  logic                    answer_given;
  logic [1:0]              res_status;
  logic [OUT_IDX_W-1:0]    res_first;
  logic [OUT_IDX_W-1:0]    res_second;
  logic                    match;
  logic                    slot_free;
  logic                    full;

  assign head_comp = $signed({target_sum[VAL_W-1], target_sum})
                   - $signed({head.item.value[VAL_W-1], head.item.value});
  assign match     = ({rdata[VAL_W-1], rdata} == comp);
  assign slot_free = !out_valid || !out_stall;
  assign full      = (count >= CNT_W'(CAPACITY));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid && !answer_given) begin
          if (full) begin
            state_next = ST_EMIT;
          end else if (count == '0) begin
            state_next = head.item.last ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ: state_next = ST_CMP;
      ST_CMP: begin
        if (match || ptr == '0) begin
          state_next = (match || cur_last) ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_EMIT: if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Take the queue head only when idle
  always_comb begin
    pop = 1'b0;
    case (state)
      ST_IDLE: pop = head.valid;
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Key store: one write, one registered read
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head.valid && !answer_given && !full && count == '0) begin
      key_mem[IDX_W'(0)] <= head.item.value;
    end else if (state == ST_CMP && !match && ptr == '0) begin
      key_mem[count[IDX_W-1:0]] <= cur_value;
    end
    if (state == ST_READ) begin
      rdata <= key_mem[ptr];
    end
  end

  // Per-array bookkeeping and pending result
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      answer_given <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            cur_value <= head.item.value;
            cur_last  <= head.item.last;
            comp      <= head_comp;
            ptr       <= IDX_W'(count - CNT_W'(1));
            if (answer_given) begin
              if (head.item.last) begin
                count        <= '0;
                answer_given <= 1'b0;
              end
            end else if (full) begin
              res_status   <= STATUS_OVERFLOW;
              res_first    <= '0;
              res_second   <= '0;
              answer_given <= !head.item.last;
              if (head.item.last) count <= '0;
            end else if (count == '0) begin
              res_status <= STATUS_NONE;
              res_first  <= '0;
              res_second <= '0;
              count      <= head.item.last ? '0 : CNT_W'(1);
            end
          end
        end
        ST_CMP: begin
          if (match) begin
            res_status   <= STATUS_FOUND;
            res_first    <= OUT_IDX_W'(ptr);
            res_second   <= OUT_IDX_W'(count);
            answer_given <= !cur_last;
            if (cur_last) count <= '0;
          end else if (ptr == '0) begin
            res_status <= STATUS_NONE;
            res_first  <= '0;
            res_second <= '0;
            count      <= cur_last ? '0 : count + CNT_W'(1);
          end else begin
            ptr <= ptr - IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && slot_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && slot_free) begin
      status       <= res_status;
      first_index  <= res_first;
      second_index <= res_second;
    end
  end

  `PSIF_ASSERT_NEXT(a_read_then_cmp, state == ST_READ, state == ST_CMP, "read without compare")
  `PSIF_ASSERT(a_count_bound, count <= CNT_W'(CAPACITY), "element count past capacity")
  `PSIF_ASSERT(a_no_scan_after_answer, answer_given |-> state != ST_READ, "scan after answer")
endmodule

>>> hdl/pair_sum_index_finder.sv
// Top level of the pair-sum finder
`timescale 1ns / 1ps
// Finds two elements of an array that add up to target_sum. Elements arrive
// one per request; each is checked against the earlier elements of its array
// by a backward scan of a single-port key memory, newest first, with a read
// state and a compare state per stored element; a result is handed over
// through the emit state. The front end queues up to two requests while
// the scan runs. The latest earlier match is reported (status 0), status 1
// flags an array with no pair, status 2 an array longer than the store. The
// store is emptied by resetting its fill count, with no clearing pass.
module pair_sum_index_finder (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [psif_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [psif_pkg::VAL_W-1:0]    element_value,
  input  logic                                 is_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           status,
  output logic [psif_pkg::OUT_IDX_W-1:0]       first_index,
  output logic [psif_pkg::OUT_IDX_W-1:0]       second_index
);
  import psif_pkg::*;

  logic signed [VAL_W-1:0] target_sum;
  head_t                   head;
  logic                    pop;

  psif_front u_front (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid(in_valid), .stall(in_stall), .element_value, .is_last,
    .target_sum, .head, .pop
  );

  psif_back u_back (
    .clk, .rst, .target_sum, .head, .pop,
    .out_valid, .out_stall, .status, .first_index, .second_index
  );
endmodule
